// ===== rtl/dnbs_pkg.sv =====
`default_nettype none

package dnbs_pkg;

    // default field widths
    localparam int COORD_BITS_DEF = 16;
    localparam int ID_BITS_DEF    = 16;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BASE_LEFT       = 3'd0,
        REG_BASE_RIGHT      = 3'd1,
        REG_BASE_TOP        = 3'd2,
        REG_BASE_BOTTOM     = 3'd3,
        REG_BASE_ID         = 3'd4,
        REG_SEARCH_AXIS     = 3'd5,
        REG_SEARCH_BACKWARD = 3'd6
    } cfg_reg_t;

    // search axis codes
    localparam logic AXIS_VERTICAL   = 1'b0;
    localparam logic AXIS_HORIZONTAL = 1'b1;

    // direction codes
    localparam logic DIR_UP_RIGHT  = 1'b0;
    localparam logic DIR_DOWN_LEFT = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/directional_nearest_box_search_top.sv =====
`default_nettype none

// channel   | dir | handshake           | payload
// ----------+-----+---------------------+-------------------------------------------
// s_ (box)  | in  | s_tvalid / s_tready | s_tdata: box_id, left, right, top, bottom
//           |     |                     | s_tlast: is_last
// m_ (res)  | out | m_tvalid / m_tready | m_tdata: nearest_id, gap; m_tuser: found
// cfg_      | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (cfg_ready always high)
//
// one box word per cycle while no last word waits behind a held result; an accepted
// word enters the input register and a last word then loads the result register; the
// rate-setting loop is the best-gap/best-id register update, one compare and one subtract deep
// aresetn (sync, active low) clears the search state, config registers and both valids
// a stalled m_ side holds the result; the input register keeps taking words until
// a last word is waiting behind the held result

module directional_nearest_box_search_top #(
    parameter int COORD_BITS = dnbs_pkg::COORD_BITS_DEF,
    parameter int ID_BITS    = dnbs_pkg::ID_BITS_DEF,
    localparam int S_DATA_BITS = ((ID_BITS + 4 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_BITS = ((ID_BITS + COORD_BITS + 7) / 8) * 8,
    localparam int CFG_BITS    = (COORD_BITS > ID_BITS) ? COORD_BITS : ID_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dnbs_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]               cfg_data,
    // box stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // box_id, box_left, box_right, box_top, box_bottom, zero pad
    input  wire logic [S_DATA_BITS-1:0]            s_tdata,
    input  wire logic                              s_tlast,   // is_last
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // nearest_id, gap, zero pad
    output logic [M_DATA_BITS-1:0]                 m_tdata,
    output logic                                   m_tuser    // found
);
    import dnbs_pkg::*;

    // configuration registers
    logic signed [COORD_BITS-1:0] base_left_reg;
    logic signed [COORD_BITS-1:0] base_right_reg;
    logic signed [COORD_BITS-1:0] base_top_reg;
    logic signed [COORD_BITS-1:0] base_bottom_reg;
    logic        [ID_BITS-1:0]    base_id_reg;
    logic                         search_axis_reg;
    logic                         search_backward_reg;

    // input register
    logic                         in_valid_reg;
    logic        [ID_BITS-1:0]    box_id_reg;
    logic signed [COORD_BITS-1:0] box_left_reg;
    logic signed [COORD_BITS-1:0] box_right_reg;
    logic signed [COORD_BITS-1:0] box_top_reg;
    logic signed [COORD_BITS-1:0] box_bottom_reg;
    logic                         in_last_reg;

    // running search state
    logic [COORD_BITS:0]          best_gap_reg;
    logic [ID_BITS-1:0]           best_id_reg;
    logic                         any_found_reg;
    logic [COORD_BITS:0]          best_gap_next;
    logic [ID_BITS-1:0]           best_id_next;
    logic                         any_found_next;

    // result register
    logic                         out_valid_reg;
    logic [ID_BITS-1:0]           out_id_reg;
    logic [COORD_BITS-1:0]        out_gap_reg;
    logic                         out_found_reg;
    logic [ID_BITS-1:0]           out_id_next;
    logic [COORD_BITS-1:0]        out_gap_next;

    logic                         cand;
    logic [COORD_BITS-1:0]        gap;
    logic                         take;
    logic                         advance;
    logic                         s_accept;
    cfg_reg_t                     cfg_sel;

    // config writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_sel   = cfg_reg_t'(cfg_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_left_reg       <= '0;
            base_right_reg      <= '0;
            base_top_reg        <= '0;
            base_bottom_reg     <= '0;
            base_id_reg         <= '0;
            search_axis_reg     <= 1'b0;
            search_backward_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_sel)
                REG_BASE_LEFT:       base_left_reg       <= cfg_data[COORD_BITS-1:0];
                REG_BASE_RIGHT:      base_right_reg      <= cfg_data[COORD_BITS-1:0];
                REG_BASE_TOP:        base_top_reg        <= cfg_data[COORD_BITS-1:0];
                REG_BASE_BOTTOM:     base_bottom_reg     <= cfg_data[COORD_BITS-1:0];
                REG_BASE_ID:         base_id_reg         <= cfg_data[ID_BITS-1:0];
                REG_SEARCH_AXIS:     search_axis_reg     <= cfg_data[0];
                REG_SEARCH_BACKWARD: search_backward_reg <= cfg_data[0];
                default: ;  // index beyond the register list: ignored
            endcase
        end
    end

    // the word in the input register moves on unless it is a last word and
    // the result register is still held by the sink
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // unpack tdata from the lowest bit up
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            box_id_reg     <= s_tdata[ID_BITS-1:0];
            box_left_reg   <= s_tdata[ID_BITS                  +: COORD_BITS];
            box_right_reg  <= s_tdata[ID_BITS + COORD_BITS     +: COORD_BITS];
            box_top_reg    <= s_tdata[ID_BITS + 2 * COORD_BITS +: COORD_BITS];
            box_bottom_reg <= s_tdata[ID_BITS + 3 * COORD_BITS +: COORD_BITS];
            in_last_reg    <= s_tlast;
        end
    end

    // overlap tests and gap for the active axis
    dnbs_judge #(
        .COORD_BITS (COORD_BITS)
    ) u_judge (
        .search_axis     (search_axis_reg),
        .search_backward (search_backward_reg),
        .base_left       (base_left_reg),
        .base_right      (base_right_reg),
        .base_top        (base_top_reg),
        .base_bottom     (base_bottom_reg),
        .box_left        (box_left_reg),
        .box_right       (box_right_reg),
        .box_top         (box_top_reg),
        .box_bottom      (box_bottom_reg),
        .cand            (cand),
        .gap             (gap)
    );

    // strict less-than keeps the earliest box on a tie; the base box itself is skipped
    assign take = cand && (box_id_reg != base_id_reg) &&
                  (!any_found_reg || ({1'b0, gap} < best_gap_reg));

    always_comb begin
        best_gap_next  = take ? {1'b0, gap} : best_gap_reg;
        best_id_next   = take ? box_id_reg  : best_id_reg;
        any_found_next = take || any_found_reg;
        out_id_next    = any_found_next ? best_id_next : base_id_reg;
        out_gap_next   = any_found_next ? best_gap_next[COORD_BITS-1:0] : '0;
    end

    // search state: cleared to the sentinel after each last word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_gap_reg  <= '1;
            best_id_reg   <= '0;
            any_found_reg <= 1'b0;
        end else if (advance) begin
            if (in_last_reg) begin
                best_gap_reg  <= '1;
                best_id_reg   <= '0;
                any_found_reg <= 1'b0;
            end else begin
                best_gap_reg  <= best_gap_next;
                best_id_reg   <= best_id_next;
                any_found_reg <= any_found_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_id_reg    <= out_id_next;
            out_gap_reg   <= out_gap_next;
            out_found_reg <= any_found_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;

    always_comb begin
        m_tdata                       = '0;
        m_tdata[ID_BITS-1:0]          = out_id_reg;
        m_tdata[ID_BITS +: COORD_BITS] = out_gap_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/dnbs_judge.sv =====
`default_nettype none

module dnbs_judge #(
    parameter int COORD_BITS = dnbs_pkg::COORD_BITS_DEF
) (
    input  wire logic                         search_axis,
    input  wire logic                         search_backward,
    input  wire logic signed [COORD_BITS-1:0] base_left,
    input  wire logic signed [COORD_BITS-1:0] base_right,
    input  wire logic signed [COORD_BITS-1:0] base_top,
    input  wire logic signed [COORD_BITS-1:0] base_bottom,
    input  wire logic signed [COORD_BITS-1:0] box_left,
    input  wire logic signed [COORD_BITS-1:0] box_right,
    input  wire logic signed [COORD_BITS-1:0] box_top,
    input  wire logic signed [COORD_BITS-1:0] box_bottom,
    output logic                              cand,
    output logic             [COORD_BITS-1:0] gap
);
    import dnbs_pkg::*;

    logic overlap_x;
    logic overlap_y;
    logic signed [COORD_BITS:0] lo_diff;
    logic signed [COORD_BITS:0] hi_diff;
    logic        below_lo;
    logic        above_hi;

    assign overlap_x = (base_right >= box_left) && (base_left <= box_right);
    assign overlap_y = (base_bottom >= box_top) && (base_top <= box_bottom);

    // pick the span pair of the active axis, then apply the gap rule
    always_comb begin
        if (search_axis == AXIS_VERTICAL) begin
            below_lo = base_top > box_bottom;
            above_hi = box_top > base_bottom;
            lo_diff  = {base_top[COORD_BITS-1], base_top}
                     - {box_bottom[COORD_BITS-1], box_bottom};
            hi_diff  = {box_top[COORD_BITS-1], box_top}
                     - {base_bottom[COORD_BITS-1], base_bottom};
        end else begin
            below_lo = base_left > box_right;
            above_hi = box_left > base_right;
            lo_diff  = {base_left[COORD_BITS-1], base_left}
                     - {box_right[COORD_BITS-1], box_right};
            hi_diff  = {box_left[COORD_BITS-1], box_left}
                     - {base_right[COORD_BITS-1], base_right};
        end

        // difference of two in-range coords always fits coord_bits unsigned
        if (below_lo) begin
            gap = lo_diff[COORD_BITS-1:0];
        end else if (above_hi) begin
            gap = hi_diff[COORD_BITS-1:0];
        end else begin
            gap = '0;
        end

        if (search_axis == AXIS_VERTICAL) begin
            cand = overlap_x && !overlap_y &&
                   ((search_backward == DIR_UP_RIGHT) ? below_lo : above_hi);
        end else begin
            cand = overlap_y && !overlap_x &&
                   ((search_backward == DIR_UP_RIGHT) ? above_hi : below_lo);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dnbs_checker.sv =====
`default_nettype none

module dnbs_checker #(
    parameter int COORD_BITS = dnbs_pkg::COORD_BITS_DEF,
    parameter int ID_BITS    = dnbs_pkg::ID_BITS_DEF,
    localparam int M_DATA_BITS = ((ID_BITS + COORD_BITS + 7) / 8) * 8
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   s_tlast,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [M_DATA_BITS-1:0] m_tdata,
    input wire logic                   m_tuser
);
    import dnbs_pkg::*;

    // held result does not change under backpressure
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no candidate means the gap field reads zero
    a_gap_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[ID_BITS +: COORD_BITS] == '0)
        else $error("nonzero gap without a found box");

    // a fresh result comes from a last word that was taken and passed through the input
    // register into the result register; the check looks back to that accept
    a_res_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a preceding last word");

endmodule

bind directional_nearest_box_search_top dnbs_checker #(
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS)
) u_dnbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== dv/directional_nearest_box_search_top_tb.sv =====
`default_nettype none

module directional_nearest_box_search_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dnbs_pkg::*;

    localparam int RANDOM_BOXES  = 1850;
    localparam int SETTLE_CYCLES = 4;     // pipeline is 2 deep, leave some margin
    localparam int STALL_LIMIT   = 1000;  // cycles with no word moving on any channel
    localparam int PRINT_LIMIT   = 40;

    // where a generated span sits against the base span on one axis
    localparam int SPAN_OVERLAP = 0;
    localparam int SPAN_LOWER   = 1;  // smaller coordinates (above or left)
    localparam int SPAN_HIGHER  = 2;  // larger coordinates (below or right)

    typedef struct {
        logic [15:0]        id;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] top;
        logic signed [15:0] bottom;
        logic               last;
    } box_t;

    typedef struct {
        logic [15:0] id;
        logic        found;
        logic [15:0] gap;
    } result_t;

    typedef struct {
        bit      typed;
        result_t want;
    } answer_t;

    // one row of the directed table: either a register write or a box word
    typedef struct {
        bit          is_cfg;
        cfg_reg_t    sel;
        logic [15:0] value;
        box_t        box;
        bit          typed;
        result_t     want;
    } step_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic [79:0] s_tdata   = '0;  // box_id, left, right, top, bottom
    logic        s_tlast   = 1'b0;  // is_last
    logic        m_tready  = 1'b0;
    wire         cfg_ready;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;  // nearest_id, gap
    wire         m_tuser;  // found

    // shadow of the base registers as the block holds them
    logic signed [15:0] base_l, base_r, base_t, base_b;
    logic [15:0]        base_idx;
    logic               axis_sel, dir_sel;

    // running search state
    logic [16:0] near_gap;
    logic [15:0] near_id;
    logic        near_valid;

    result_t pending_results[$];
    answer_t fixed_answers[$];
    int      err_count   = 0;
    int      idle_cycles = 0;
    bit      calm        = 1'b0;

    directional_nearest_box_search_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic signed [15:0] clip(input int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic int rnd(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // distance between base span [alo, ahi] and box span [blo, bhi]
    function automatic int span_gap(input int alo, input int ahi, input int blo, input int bhi);
        if (alo > bhi) return alo - bhi;
        if (blo > ahi) return blo - ahi;
        return 0;
    endfunction

    // judge one box against the base, fold it into the search, report on last
    function automatic void judge_box(input box_t b, output bit gives, output result_t r);
        int  ql, qr, qt, qb, bl, br, bt, bb, g;
        bit  ox, oy, cand;
        ql = base_l;  qr = base_r;  qt = base_t;  qb = base_b;
        bl = b.left;  br = b.right; bt = b.top;   bb = b.bottom;
        if (b.id != base_idx) begin
            ox   = (qr >= bl) && (ql <= br);
            oy   = (qb >= bt) && (qt <= bb);
            cand = 1'b0;
            g    = 0;
            if (axis_sel == AXIS_VERTICAL) begin
                if (ox && !oy) begin
                    g    = span_gap(qt, qb, bt, bb);
                    cand = (dir_sel == DIR_UP_RIGHT) ? (bb < qt) : (bt > qb);
                end
            end else begin
                if (oy && !ox) begin
                    g    = span_gap(ql, qr, bl, br);
                    cand = (dir_sel == DIR_UP_RIGHT) ? (bl > qr) : (br < ql);
                end
            end
            // strict compare keeps the earliest box on a tie
            if (cand && (!near_valid || g < near_gap)) begin
                near_gap   = 17'(g);
                near_id    = b.id;
                near_valid = 1'b1;
            end
        end
        gives   = b.last;
        r.id    = near_valid ? near_id : base_idx;
        r.found = near_valid;
        r.gap   = near_valid ? near_gap[15:0] : 16'd0;
        if (b.last) begin
            near_gap   = '1;
            near_id    = '0;
            near_valid = 1'b0;
        end
    endfunction

    function automatic void span_near(input int lo, input int hi, input int side, input int reach,
                                      output int a, output int b);
        case (side)
            SPAN_OVERLAP: begin
                a = lo - rnd(0, reach);
                if ($urandom_range(0, 1) != 0) a += rnd(0, (hi > lo) ? hi - lo : 0);
                b = ((a > lo) ? a : lo) + rnd(0, reach);
            end
            SPAN_LOWER: begin
                b = lo - rnd(0, reach);
                a = b - rnd(0, reach);
            end
            default: begin
                a = hi + rnd(0, reach);
                b = a + rnd(0, reach);
            end
        endcase
    endfunction

    function automatic step_t box_row(input logic [15:0] id, input int l, input int r,
                                      input int t, input int bt, input bit last);
        step_t s;
        s.is_cfg     = 1'b0;
        s.sel        = REG_BASE_LEFT;
        s.value      = '0;
        s.box.id     = id;
        s.box.left   = clip(l);
        s.box.right  = clip(r);
        s.box.top    = clip(t);
        s.box.bottom = clip(bt);
        s.box.last   = last;
        s.typed      = 1'b0;
        s.want       = '{16'd0, 1'b0, 16'd0};
        return s;
    endfunction

    function automatic step_t cfg_row(input cfg_reg_t sel, input int value);
        step_t s;
        s        = box_row(16'd0, 0, 0, 0, 0, 1'b0);
        s.is_cfg = 1'b1;
        s.sel    = sel;
        s.value  = 16'(value);
        return s;
    endfunction

    function automatic step_t hand_answer(input step_t s, input logic [15:0] id,
                                          input logic found, input logic [15:0] gap);
        step_t t;
        t       = s;
        t.typed = 1'b1;
        t.want  = '{id, found, gap};
        return t;
    endfunction

    task automatic flag_error(input string msg);
        if (err_count < PRINT_LIMIT) $display("mismatch at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // present one box word, holding it until taken
    task automatic send_box(input box_t b, input bit typed, input result_t want);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        if (b.last) fixed_answers.push_back('{typed, want});
        s_tvalid <= 1'b1;
        s_tdata  <= {b.bottom, b.top, b.right, b.left, b.id};
        s_tlast  <= b.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // register writes only once the block has gone quiet
    task automatic write_reg(input cfg_reg_t sel, input logic [15:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // prediction and checking, all sampled at the clock edge
    always @(posedge aclk) begin : scoreboard
        box_t    b;
        result_t got;
        result_t want;
        answer_t ans;
        bit      gives;
        if (!aresetn) begin
            base_l     = '0;
            base_r     = '0;
            base_t     = '0;
            base_b     = '0;
            base_idx   = '0;
            axis_sel   = AXIS_VERTICAL;
            dir_sel    = DIR_UP_RIGHT;
            near_gap   = '1;
            near_id    = '0;
            near_valid = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.id    = m_tdata[15:0];
                got.gap   = m_tdata[31:16];
                got.found = m_tuser;
                if (pending_results.size() == 0) begin
                    flag_error($sformatf("result word with nothing expected, id %0d", got.id));
                end else begin
                    want = pending_results.pop_front();
                    if (got.id !== want.id)
                        flag_error($sformatf("nearest_id %0d, wanted %0d", got.id, want.id));
                    if (got.found !== want.found)
                        flag_error($sformatf("found %0b, wanted %0b", got.found, want.found));
                    if (got.gap !== want.gap)
                        flag_error($sformatf("gap %0d, wanted %0d", got.gap, want.gap));
                end
            end
            if (s_tvalid && s_tready) begin
                b.id     = s_tdata[15:0];
                b.left   = s_tdata[31:16];
                b.right  = s_tdata[47:32];
                b.top    = s_tdata[63:48];
                b.bottom = s_tdata[79:64];
                b.last   = s_tlast;
                judge_box(b, gives, want);
                if (gives) begin
                    // hand-typed answer takes the place of the prediction
                    if (fixed_answers.size() != 0) begin
                        ans = fixed_answers.pop_front();
                        if (ans.typed) want = ans.want;
                    end
                    pending_results.push_back(want);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_BASE_LEFT:       base_l   = cfg_data;
                    REG_BASE_RIGHT:      base_r   = cfg_data;
                    REG_BASE_TOP:        base_t   = cfg_data;
                    REG_BASE_BOTTOM:     base_b   = cfg_data;
                    REG_BASE_ID:         base_idx = cfg_data;
                    REG_SEARCH_AXIS:     axis_sel = cfg_data[0];
                    REG_SEARCH_BACKWARD: dir_sel  = cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // watchdog on words moving anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL directional_nearest_box_search_top");
            $finish;
        end
    end

    // result side back-pressure in bursts
    initial begin : result_pacer
        forever begin
            if (calm || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        step_t   rows[$];
        box_t    b;
        result_t none;
        int      n_sent, sets, len, reach, kind, across, along;
        int      vals[4];
        int      xa, xb, ya, yb;
        logic [15:0] pick_id;
        logic    pick_axis, pick_dir;

        none   = '{16'd0, 1'b0, 16'd0};
        n_sent = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset the base is box 0, so a lone box 0 is skipped
        rows.push_back(hand_answer(box_row(16'd0, 0, 0, 0, 0, 1'b1), 16'd0, 1'b0, 16'd0));
        rows.push_back(box_row(16'hffff, -32768, 32767, -32768, -32768, 1'b1));
        rows.push_back(cfg_row(REG_BASE_LEFT, -100));
        rows.push_back(cfg_row(REG_BASE_RIGHT, 100));
        rows.push_back(cfg_row(REG_BASE_TOP, -50));
        rows.push_back(cfg_row(REG_BASE_BOTTOM, 50));
        rows.push_back(cfg_row(REG_BASE_ID, 7));
        rows.push_back(cfg_row(REG_SEARCH_AXIS, AXIS_VERTICAL));
        rows.push_back(cfg_row(REG_SEARCH_BACKWARD, DIR_UP_RIGHT));
        // vertical up: a far box, a box touching in y, a box touching in x,
        // the base itself, and a tie that must lose to the earlier box
        rows.push_back(box_row(16'd3, -10, 10, -300, -80, 1'b0));
        rows.push_back(box_row(16'd4, 90, 200, -200, -50, 1'b0));
        rows.push_back(box_row(16'd5, 100, 120, -110, -60, 1'b0));
        rows.push_back(box_row(16'd7, -5, 5, -70, -55, 1'b0));
        rows.push_back(hand_answer(box_row(16'd6, -100, -100, -30000, -60, 1'b1),
                                   16'd5, 1'b1, 16'd10));
        rows.push_back(cfg_row(REG_SEARCH_BACKWARD, DIR_DOWN_LEFT));
        rows.push_back(box_row(16'd9, -32768, 32767, 32767, 32767, 1'b1));
        // widest possible gap
        rows.push_back(cfg_row(REG_BASE_TOP, 32767));
        rows.push_back(cfg_row(REG_BASE_BOTTOM, 32767));
        rows.push_back(cfg_row(REG_SEARCH_BACKWARD, DIR_UP_RIGHT));
        rows.push_back(hand_answer(box_row(16'd12, 0, 0, -32768, -32768, 1'b1),
                                   16'd12, 1'b1, 16'hffff));
        // horizontal, right then left
        rows.push_back(cfg_row(REG_BASE_TOP, -50));
        rows.push_back(cfg_row(REG_BASE_BOTTOM, 50));
        rows.push_back(cfg_row(REG_SEARCH_AXIS, AXIS_HORIZONTAL));
        rows.push_back(box_row(16'd20, 150, 200, 0, 0, 1'b0));
        rows.push_back(box_row(16'd21, -300, -200, 0, 0, 1'b1));
        rows.push_back(cfg_row(REG_SEARCH_BACKWARD, DIR_DOWN_LEFT));
        // inverted box (left above right) is judged as given
        rows.push_back(box_row(16'd23, 300, -300, -50, -50, 1'b0));
        rows.push_back(box_row(16'd24, -200, -150, 60, 90, 1'b0));
        // axis flips in the middle of a set
        rows.push_back(cfg_row(REG_SEARCH_AXIS, AXIS_VERTICAL));
        rows.push_back(box_row(16'd25, -20, 20, 70, 80, 1'b1));
        // nothing qualifies: the base index comes back
        rows.push_back(cfg_row(REG_BASE_ID, 16'hffff));
        rows.push_back(box_row(16'hffff, 0, 0, 100, 100, 1'b0));
        rows.push_back(hand_answer(box_row(16'd0, 500, 600, 100, 100, 1'b1),
                                   16'hffff, 1'b0, 16'd0));

        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_reg(rows[i].sel, rows[i].value);
            else send_box(rows[i].box, rows[i].typed, rows[i].want);
        end

        // random phases: new base, then sets of boxes placed around it
        while (n_sent < RANDOM_BOXES) begin
            if (n_sent > RANDOM_BOXES * 9 / 10) calm = 1'b1;

            vals[0] = rnd(-20000, 20000);
            vals[2] = rnd(-20000, 20000);
            vals[1] = vals[0] + rnd(0, 1500);
            vals[3] = vals[2] + rnd(0, 1500);
            vals[0] = vals[0] - rnd(0, 1500);
            vals[2] = vals[2] - rnd(0, 1500);
            for (int i = 0; i < 4; i++) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) vals[i] = -32768;
                else if (kind == 1) vals[i] = 32767;
                else if (kind == 2) vals[i] = rnd(-32768, 32767);
                vals[i] = clip(vals[i]);
            end
            kind = $urandom_range(0, 7);
            pick_id   = (kind == 0) ? 16'd0 : (kind == 1) ? 16'hffff
                                            : 16'($urandom_range(0, 65535));
            pick_axis = $urandom_range(0, 1) ? AXIS_HORIZONTAL : AXIS_VERTICAL;
            pick_dir  = $urandom_range(0, 1) ? DIR_DOWN_LEFT : DIR_UP_RIGHT;
            write_reg(REG_BASE_LEFT, 16'(vals[0]));
            write_reg(REG_BASE_RIGHT, 16'(vals[1]));
            write_reg(REG_BASE_TOP, 16'(vals[2]));
            write_reg(REG_BASE_BOTTOM, 16'(vals[3]));
            write_reg(REG_BASE_ID, pick_id);
            write_reg(REG_SEARCH_AXIS, {15'd0, pick_axis});
            write_reg(REG_SEARCH_BACKWARD, {15'd0, pick_dir});

            // a tight reach crowds boxes together so gaps tie often
            reach = ($urandom_range(0, 3) == 0) ? 6 : rnd(20, 3000);
            sets  = rnd(2, 8);
            repeat (sets) begin
                len = rnd(1, 12);
                for (int k = 0; k < len; k++) begin
                    kind = $urandom_range(0, 9);
                    b.id = 16'($urandom_range(0, 65535));
                    if (kind < 2) begin
                        // noise, inverted boxes included
                        b.left   = 16'($urandom);
                        b.right  = 16'($urandom);
                        b.top    = 16'($urandom);
                        b.bottom = 16'($urandom);
                    end else begin
                        if (kind == 2) b.id = pick_id;
                        across = ($urandom_range(0, 4) == 0) ? SPAN_OVERLAP
                               : ($urandom_range(0, 1) ? SPAN_HIGHER : SPAN_LOWER);
                        along  = ($urandom_range(0, 4) == 0)
                               ? ($urandom_range(0, 1) ? SPAN_HIGHER : SPAN_LOWER)
                               : SPAN_OVERLAP;
                        if (pick_axis == AXIS_VERTICAL) begin
                            span_near(vals[0], vals[1], along, reach, xa, xb);
                            span_near(vals[2], vals[3], across, reach, ya, yb);
                        end else begin
                            span_near(vals[0], vals[1], across, reach, xa, xb);
                            span_near(vals[2], vals[3], along, reach, ya, yb);
                        end
                        b.left   = clip(xa);
                        b.right  = clip(xb);
                        b.top    = clip(ya);
                        b.bottom = clip(yb);
                    end
                    b.last = (k == len - 1);
                    send_box(b, 1'b0, none);
                    n_sent++;
                end
            end

            // sometimes leave a set open so the next base applies mid-set
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    b.id     = 16'($urandom_range(0, 65535));
                    b.left   = clip(vals[0] - rnd(0, 50));
                    b.right  = clip(vals[1] + rnd(0, 50));
                    b.top    = clip(vals[2] - rnd(1, 400));
                    b.bottom = clip(vals[2] - 1);
                    b.last   = 1'b0;
                    send_box(b, 1'b0, none);
                    n_sent++;
                end
            end
        end

        // drain
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (err_count == 0)
            $display("PASS directional_nearest_box_search_top");
        else
            $display("FAIL directional_nearest_box_search_top");
        $finish;
    end

endmodule

`default_nettype wire
